@@ rtl/core/sfcp_pkg.sv @@
// Shared types and constants for the sync-framed command parser.
// No dependencies; imported by the front end, queue, back end and top level.
package sfcp_pkg;

    // Sync pair that opens a frame
    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    // Frame lengths, sync bytes included
    localparam logic [3:0] LEN_STOP = 4'd3;
    localparam logic [3:0] LEN_POS  = 4'd15;
    localparam logic [3:0] LEN_NAME = 4'd4;
    localparam int unsigned DEFAULT_LEN_C = 10;

    // Frame byte positions
    localparam logic [3:0] IDX_CMD   = 4'd2;
    localparam logic [3:0] IDX_FIRST = 4'd3;

    // Payload buffer holds frame bytes 3 through 14
    localparam int unsigned BUF_ENTRIES = 12;
    localparam int unsigned BUF_IDX_W   = $clog2(BUF_ENTRIES);

    // Queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_CODE      = 2'd0,
        CFG_MOVE_POS_CODE  = 2'd1,
        CFG_MOVE_NAME_CODE = 2'd2
    } t_cfg_idx;

    // One completed frame, as handed from front to back
    typedef struct packed {
        logic [7:0]  command;
        logic        upd_pos;
        logic        upd_name;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] angle;
        logic [7:0]  name;
        logic [3:0]  frame_bytes;
    } t_frame_evt;

endpackage

@@ rtl/core/sfcp_front.sv @@
// Front end: sync hunt, frame tracking, payload buffer and command registers.
// Depends on sfcp_pkg; emits one t_frame_evt per completed frame.
module sfcp_front #(
    parameter int unsigned DEFAULT_LEN = sfcp_pkg::DEFAULT_LEN_C
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_accept,
    input  logic [7:0]                          i_byte,
    output logic                                o_push,
    output sfcp_pkg::t_frame_evt                o_evt
);
    import sfcp_pkg::*;

    logic [7:0]           r_stop_code;
    logic [7:0]           r_pos_code;
    logic [7:0]           r_name_code;
    logic [7:0]           r_prev_byte;
    logic                 r_in_frame;
    logic [3:0]           r_byte_index;
    logic [3:0]           r_frame_len;
    logic [7:0]           r_cmd;
    logic [7:0]           r_buf [BUF_ENTRIES];

    logic [7:0]           n_buf [BUF_ENTRIES];
    logic [3:0]           n_frame_len;
    logic [3:0]           n_byte_index;
    logic [BUF_IDX_W-1:0] wr_idx;
    logic                 wr_en;
    logic                 sync_hit;
    logic                 frame_done;
    logic [7:0]           cmd_now;

    // Pick the frame length on the command byte; name beats position beats stop, no match keeps it
    always_comb begin
        n_frame_len = r_frame_len;
        if (r_in_frame && r_byte_index == IDX_CMD) begin
            priority if (i_byte == r_name_code) begin
                n_frame_len = LEN_NAME;
            end else if (i_byte == r_pos_code) begin
                n_frame_len = LEN_POS;
            end else if (i_byte == r_stop_code) begin
                n_frame_len = LEN_STOP;
            end
        end
    end

    // Buffer write for payload bytes, and the buffer as it stands after it
    assign wr_en  = r_in_frame && (r_byte_index >= IDX_FIRST);
    assign wr_idx = BUF_IDX_W'(r_byte_index - IDX_FIRST);

    always_comb begin
        for (int k = 0; k < BUF_ENTRIES; k++) begin
            n_buf[k] = (wr_en && wr_idx == BUF_IDX_W'(k)) ? i_byte : r_buf[k];
        end
    end

    assign n_byte_index = r_byte_index + 4'd1;
    assign sync_hit     = !r_in_frame && r_prev_byte == SYNC_FIRST && i_byte == SYNC_SECOND;
    assign frame_done   = r_in_frame && (n_byte_index >= n_frame_len);
    assign cmd_now      = (r_byte_index == IDX_CMD) ? i_byte : r_cmd;

    // Build the frame event from the updated buffer
    assign o_push               = i_accept && frame_done;
    assign o_evt.command        = cmd_now;
    assign o_evt.upd_pos        = (cmd_now == r_pos_code);
    assign o_evt.upd_name       = (cmd_now == r_name_code);
    assign o_evt.pos_x          = {n_buf[3], n_buf[2], n_buf[1], n_buf[0]};
    assign o_evt.pos_y          = {n_buf[7], n_buf[6], n_buf[5], n_buf[4]};
    assign o_evt.angle          = {n_buf[11], n_buf[10], n_buf[9], n_buf[8]};
    assign o_evt.name           = n_buf[0];
    assign o_evt.frame_bytes    = n_frame_len;

    // Hold configuration and frame tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_code  <= 8'd0;
            r_pos_code   <= 8'd1;
            r_name_code  <= 8'd2;
            r_prev_byte  <= 8'd0;
            r_in_frame   <= 1'b0;
            r_byte_index <= 4'd0;
            r_frame_len  <= 4'(DEFAULT_LEN);
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_STOP_CODE:      r_stop_code <= i_cfg_data;
                    CFG_MOVE_POS_CODE:  r_pos_code  <= i_cfg_data;
                    CFG_MOVE_NAME_CODE: r_name_code <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                if (!r_in_frame) begin
                    if (sync_hit) begin
                        r_in_frame   <= 1'b1;
                        r_byte_index <= IDX_CMD;
                    end else begin
                        r_prev_byte <= i_byte;
                    end
                end else begin
                    r_frame_len <= n_frame_len;
                    if (frame_done) begin
                        r_in_frame   <= 1'b0;
                        r_byte_index <= 4'd0;
                        r_prev_byte  <= 8'd0;
                    end else begin
                        r_byte_index <= n_byte_index;
                    end
                end
            end
        end
    end

    // Store command and payload bytes
    always_ff @(posedge i_clk) begin
        if (i_accept && r_in_frame) begin
            if (r_byte_index == IDX_CMD) begin
                r_cmd <= i_byte;
            end
            if (wr_en) begin
                r_buf[wr_idx] <= i_byte;
            end
        end
    end

endmodule

@@ rtl/core/sfcp_queue.sv @@
// Short queue of frame events between front and back.
// Depends on sfcp_pkg for the event type and depth.
module sfcp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfcp_pkg::t_frame_evt i_evt,
    input  logic                 i_pop,
    output sfcp_pkg::t_frame_evt o_evt,
    output logic                 o_full,
    output logic                 o_empty
);
    import sfcp_pkg::*;

    t_frame_evt         r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_evt   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

endmodule

@@ rtl/core/sfcp_back.sv @@
// Back end: applies frame events to the held targets and drives the result register.
// Depends on sfcp_pkg for the event type.
module sfcp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  sfcp_pkg::t_frame_evt i_evt,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [7:0]           o_command,
    output logic [31:0]          o_pos_x_bits,
    output logic [31:0]          o_pos_y_bits,
    output logic [31:0]          o_angle_bits,
    output logic [7:0]           o_waypoint_name,
    output logic [3:0]           o_frame_bytes
);
    import sfcp_pkg::*;

    logic        r_valid;
    logic [31:0] r_held_x;
    logic [31:0] r_held_y;
    logic [31:0] r_held_angle;
    logic [7:0]  r_held_name;
    logic [7:0]  r_command;
    logic [3:0]  r_frame_bytes;
    logic [31:0] n_held_x;
    logic [31:0] n_held_y;
    logic [31:0] n_held_angle;
    logic [7:0]  n_held_name;

    // Take the next event when the result register is free or being drained
    assign o_pop = !i_q_empty && (!r_valid || !i_stall);

    // Merge the event into the held targets
    assign n_held_x     = i_evt.upd_pos  ? i_evt.pos_x : r_held_x;
    assign n_held_y     = i_evt.upd_pos  ? i_evt.pos_y : r_held_y;
    assign n_held_angle = i_evt.upd_pos  ? i_evt.angle : r_held_angle;
    assign n_held_name  = i_evt.upd_name ? i_evt.name  : r_held_name;

    // Hold targets and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_held_x     <= 32'd0;
            r_held_y     <= 32'd0;
            r_held_angle <= 32'd0;
            r_held_name  <= 8'd0;
        end else begin
            if (o_pop) begin
                r_valid      <= 1'b1;
                r_held_x     <= n_held_x;
                r_held_y     <= n_held_y;
                r_held_angle <= n_held_angle;
                r_held_name  <= n_held_name;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the per-frame result fields
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_command     <= i_evt.command;
            r_frame_bytes <= i_evt.frame_bytes;
        end
    end

    assign o_valid         = r_valid;
    assign o_command       = r_command;
    assign o_pos_x_bits    = r_held_x;
    assign o_pos_y_bits    = r_held_y;
    assign o_angle_bits    = r_held_angle;
    assign o_waypoint_name = r_held_name;
    assign o_frame_bytes   = r_frame_bytes;

endmodule

@@ rtl/core/sync_framed_command_parser.sv @@
// Sync-framed command parser: takes one byte per cycle, gives one result per frame.
// A frame's event enters the event queue when its last byte is accepted, and the
// result register loads from the queue. Throughput: one byte per cycle; the input
// stalls only when the two-entry event queue is full, which needs a stalled result.
// Reset (i_rst_n low, synchronous) clears frame tracking, held targets and the
// queue, and loads the command codes 0, 1, 2 and a frame length of DEFAULT_LEN.
module sync_framed_command_parser #(
    parameter int unsigned DEFAULT_LEN = sfcp_pkg::DEFAULT_LEN_C
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_byte_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_command,
    output logic [31:0]                    o_pos_x_bits,
    output logic [31:0]                    o_pos_y_bits,
    output logic [31:0]                    o_angle_bits,
    output logic [7:0]                     o_waypoint_name,
    output logic [3:0]                     o_frame_bytes
);
    import sfcp_pkg::*;

    t_frame_evt push_evt;
    t_frame_evt pop_evt;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    logic       in_accept;

    // Stall input while the queue is full
    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    sfcp_front #(
        .DEFAULT_LEN (DEFAULT_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_byte      (i_byte_in),
        .o_push      (push),
        .o_evt       (push_evt)
    );

    sfcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .i_pop   (pop),
        .o_evt   (pop_evt),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sfcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_evt           (pop_evt),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_command       (o_command),
        .o_pos_x_bits    (o_pos_x_bits),
        .o_pos_y_bits    (o_pos_y_bits),
        .o_angle_bits    (o_angle_bits),
        .o_waypoint_name (o_waypoint_name),
        .o_frame_bytes   (o_frame_bytes)
    );

endmodule

@@ rtl/core/sfcp_checker.sv @@
// Port-level checks for the sync-framed command parser, bound to the top level.
// Depends on the top level's port list and its DEFAULT_LEN parameter only.
module sfcp_checker #(
    parameter int unsigned DEFAULT_LEN = 10
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_command,
    input logic [31:0] o_pos_x_bits,
    input logic [3:0]  o_frame_bytes
);

    // Result register comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Input backpressure only builds up behind a pending result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // Frame length is one of the command lengths or the reset default
    a_frame_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_bytes == 4'd3 || o_frame_bytes == 4'd4 ||
                     o_frame_bytes == 4'd15 || o_frame_bytes == 4'(DEFAULT_LEN)))
        else $error("illegal frame length on result");

    // Stalled result holds its fields
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_command) &&
                               $stable(o_pos_x_bits) && $stable(o_frame_bytes))
        else $error("stalled result changed");

endmodule

bind sync_framed_command_parser sfcp_checker #(
    .DEFAULT_LEN (DEFAULT_LEN)
) u_sfcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_command     (o_command),
    .o_pos_x_bits  (o_pos_x_bits),
    .o_frame_bytes (o_frame_bytes)
);

@@ dv/tb_sync_framed_command_parser.sv @@
// Self-checking testbench for sync_framed_command_parser: byte streams in, frame reports out.
// Depends on rtl/core/sfcp_pkg.sv and the parser RTL; predicts every report internally
// and runs directed frames, shared-code settings, backpressure and random traffic.
`timescale 1ns / 1ps

module tb_sync_framed_command_parser;
    import sfcp_pkg::*;

    localparam int unsigned CLK_PERIOD     = 4;
    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTED   = 10;

    // Command codes loaded at reset
    localparam logic [7:0] RESET_STOP_CODE = 8'd0;
    localparam logic [7:0] RESET_POS_CODE  = 8'd1;
    localparam logic [7:0] RESET_NAME_CODE = 8'd2;
    localparam logic [7:0] ODD_COMMAND     = 8'h7E;
    localparam logic [7:0] FILL_BYTE       = 8'h00;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // Opening stream: repeated first sync byte, odd command at the default length ending
    // in a first sync byte, a lone second sync byte, then position, name and stop frames
    localparam int unsigned OPENING_LEN = 34;
    localparam logic [7:0] OPENING [OPENING_LEN] = '{
        SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, ODD_COMMAND,
        8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, SYNC_FIRST,
        SYNC_SECOND,
        SYNC_FIRST, SYNC_SECOND, RESET_POS_CODE,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h80, 8'h3F,
        SYNC_FIRST, SYNC_SECOND, RESET_NAME_CODE, 8'hFF,
        SYNC_FIRST, SYNC_SECOND, RESET_STOP_CODE
    };

    typedef struct packed {
        logic [7:0]  command;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] angle;
        logic [7:0]  name;
        logic [3:0]  frame_bytes;
    } t_frame_report;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_STOP_CODE;
    logic [7:0]           i_cfg_data  = 8'd0;
    logic                 i_valid     = 1'b0;
    logic [7:0]           i_byte_in   = 8'd0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [7:0]           o_command;
    logic [31:0]          o_pos_x_bits;
    logic [31:0]          o_pos_y_bits;
    logic [31:0]          o_angle_bits;
    logic [7:0]           o_waypoint_name;
    logic [3:0]           o_frame_bytes;

    // Parser state as predicted
    logic [7:0]  code_stop  = RESET_STOP_CODE;
    logic [7:0]  code_pos   = RESET_POS_CODE;
    logic [7:0]  code_name  = RESET_NAME_CODE;
    logic [7:0]  last_byte  = 8'd0;
    logic        framing    = 1'b0;
    logic [3:0]  frame_pos  = 4'd0;
    logic [3:0]  cur_len    = 4'(DEFAULT_LEN_C);
    logic [7:0]  frame_mem [16] = '{default: 8'd0};
    logic [31:0] target_x     = 32'd0;
    logic [31:0] target_y     = 32'd0;
    logic [31:0] target_angle = 32'd0;
    logic [7:0]  target_name  = 8'd0;

    t_frame_report frame_reports_due [$];

    int unsigned err_count    = 0;
    int unsigned bytes_sent   = 0;
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    int unsigned stuck_cycles = 0;
    int unsigned hold_left    = 0;
    logic [7:0]  hold_req     = 8'd0;
    logic [7:0]  hold_seen    = 8'd0;

    sync_framed_command_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_byte_in       (i_byte_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_command       (o_command),
        .o_pos_x_bits    (o_pos_x_bits),
        .o_pos_y_bits    (o_pos_y_bits),
        .o_angle_bits    (o_angle_bits),
        .o_waypoint_name (o_waypoint_name),
        .o_frame_bytes   (o_frame_bytes)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void flag_error(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_REPORTED) begin
            $display("ERROR at %0t: %s expected %h got %h", $time, what, want, got);
        end
    endfunction

    function automatic logic [31:0] word_at(input int unsigned start);
        return {frame_mem[start + 3], frame_mem[start + 2],
                frame_mem[start + 1], frame_mem[start]};
    endfunction

    // Advance the parser by one accepted byte; queue a report when a frame closes
    function automatic void parse_byte(input logic [7:0] b);
        t_frame_report rep;
        logic [7:0]    cmd;
        if (!framing) begin
            // Hunt for the sync pair
            if (last_byte == SYNC_FIRST && b == SYNC_SECOND) begin
                framing      = 1'b1;
                frame_mem[0] = SYNC_FIRST;
                frame_mem[1] = SYNC_SECOND;
                frame_pos    = IDX_CMD;
            end else begin
                last_byte = b;
            end
            return;
        end
        // Command byte picks the length; the last matching code wins
        if (frame_pos == IDX_CMD) begin
            if (b == code_stop) cur_len = LEN_STOP;
            if (b == code_pos)  cur_len = LEN_POS;
            if (b == code_name) cur_len = LEN_NAME;
        end
        frame_mem[frame_pos] = b;
        frame_pos = frame_pos + 4'd1;
        if (frame_pos < cur_len) return;

        // Frame complete: update held targets, then report
        cmd = frame_mem[IDX_CMD];
        if (cmd == code_pos) begin
            target_x     = word_at(IDX_FIRST);
            target_y     = word_at(IDX_FIRST + 4);
            target_angle = word_at(IDX_FIRST + 8);
        end
        if (cmd == code_name) target_name = frame_mem[IDX_FIRST];
        rep.command     = cmd;
        rep.pos_x       = target_x;
        rep.pos_y       = target_y;
        rep.angle       = target_angle;
        rep.name        = target_name;
        rep.frame_bytes = cur_len;
        frame_reports_due.push_back(rep);
        framing   = 1'b0;
        frame_pos = 4'd0;
        last_byte = 8'd0;
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(3))
            0:       return code_stop;
            1:       return code_pos;
            2:       return code_name;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one byte, with random idle cycles ahead of it, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] cmd);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(cmd);
        while (framing) send_byte(8'($urandom));
    endtask

    // Bytes biased toward the sync values
    task automatic send_noise(input int unsigned count);
        logic [7:0] b;
        repeat (count) begin
            case ($urandom_range(2))
                0:       b = SYNC_FIRST;
                1:       b = SYNC_SECOND;
                default: b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    task automatic await_results();
        i_valid <= 1'b0;
        while (frame_reports_due.size() != 0) @(posedge i_clk);
    endtask

    // Close any open frame, drain the reports, and let the pipeline go quiet
    task automatic settle();
        while (framing) send_byte(FILL_BYTE);
        await_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        idle_pct = sender_pct;
        stall_pct <= receiver_pct;
    endtask

    // Write all three codes plus the unused index while the parser is idle
    task automatic write_codes(input logic [7:0] stop_v, input logic [7:0] pos_v,
                               input logic [7:0] name_v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_STOP_CODE;
        i_cfg_data  <= stop_v;
        @(posedge i_clk);
        i_cfg_index <= CFG_MOVE_POS_CODE;
        i_cfg_data  <= pos_v;
        @(posedge i_clk);
        i_cfg_index <= CFG_MOVE_NAME_CODE;
        i_cfg_data  <= name_v;
        @(posedge i_clk);
        i_cfg_index <= CFG_UNUSED_IDX;
        i_cfg_data  <= 8'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        code_stop = stop_v;
        code_pos  = pos_v;
        code_name = name_v;
    endtask

    task automatic test_sync_and_commands();
        set_idling(0, 0);
        foreach (OPENING[k]) send_byte(OPENING[k]);
        settle();
    endtask

    // Mostly whole frames with random content, plus noise and cut-short frames
    task automatic test_random_traffic(input int unsigned sender_pct,
                                       input int unsigned receiver_pct,
                                       input int unsigned n_items);
        int unsigned stop_at;
        int unsigned roll;
        stop_at = bytes_sent + n_items;
        set_idling(sender_pct, receiver_pct);
        while (bytes_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                send_frame(pick_command());
            end else if (roll < 85) begin
                send_noise($urandom_range(1, 6));
            end else begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(pick_command());
                send_noise($urandom_range(0, 3));
            end
        end
        settle();
    endtask

    task automatic test_code_extremes();
        write_codes(8'hFF, 8'h00, 8'h80);
        test_random_traffic(63, 0, 75);
        write_codes(8'h00, 8'hFF, 8'h7F);
        test_random_traffic(0, 63, 75);
    endtask

    task automatic test_shared_codes();
        // Stop and position share a code: position wins, fifteen bytes
        write_codes(8'h10, 8'h10, 8'h20);
        test_random_traffic(26, 26, 60);
        // Position and name share a code: four-byte frame, words from stale buffer bytes
        write_codes(8'h30, 8'h41, 8'h41);
        test_random_traffic(26, 26, 60);
        // All three equal
        write_codes(8'hFF, 8'hFF, 8'hFF);
        test_random_traffic(0, 0, 60);
        // Stop and name share a code
        write_codes(8'h05, 8'h06, 8'h05);
        test_random_traffic(63, 0, 60);
    endtask

    // Hold the output off for a long stretch while stop frames keep coming, then a position frame
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_req <= hold_req + 8'd1;
        repeat (10) send_frame(code_stop);
        send_frame(code_pos);
        settle();
    endtask

    // Pause the sender after each frame until its report is out
    task automatic test_result_pauses();
        set_idling(63, 63);
        repeat (6) begin
            send_frame(pick_command());
            await_results();
        end
        settle();
    endtask

    task automatic test_random_codes();
        write_codes(8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(26, 26, 40);
        write_codes(8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(0, 63, 40);
        write_codes(8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(63, 0, 40);
    endtask

    // Drive output stall: a requested long hold first, otherwise random
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each accepted report with the oldest one due
    always @(posedge i_clk) begin
        t_frame_report want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (frame_reports_due.size() == 0) begin
                flag_error("report with none due, command", 32'd0, 32'(o_command));
            end else begin
                want = frame_reports_due.pop_front();
                if (o_command !== want.command)
                    flag_error("command", 32'(want.command), 32'(o_command));
                if (o_pos_x_bits !== want.pos_x)
                    flag_error("pos_x_bits", want.pos_x, o_pos_x_bits);
                if (o_pos_y_bits !== want.pos_y)
                    flag_error("pos_y_bits", want.pos_y, o_pos_y_bits);
                if (o_angle_bits !== want.angle)
                    flag_error("angle_bits", want.angle, o_angle_bits);
                if (o_waypoint_name !== want.name)
                    flag_error("waypoint_name", 32'(want.name), 32'(o_waypoint_name));
                if (o_frame_bytes !== want.frame_bytes)
                    flag_error("frame_bytes", 32'(want.frame_bytes), 32'(o_frame_bytes));
            end
        end
    end

    // Stop the run when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sync_and_commands();
        test_random_traffic(0, 0, 80);
        test_code_extremes();
        test_shared_codes();
        test_output_backpressure();
        test_result_pauses();
        test_random_codes();
        settle();

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/sfcp_pkg.sv
rtl/core/sfcp_front.sv
rtl/core/sfcp_queue.sv
rtl/core/sfcp_back.sv
rtl/core/sync_framed_command_parser.sv
rtl/core/sfcp_checker.sv
dv/tb_sync_framed_command_parser.sv
